// ----- hdl/cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared widths, codes, control types and saturation helpers for the
// two-section bandpass biquad cascade.
// ----------------------------------------------------------------------------
package cbb_pkg;

  // data widths
  localparam int SAMPLE_W  = 16;
  localparam int COEF_FRAC = 22;
  localparam int COEF_W    = 24;
  localparam int STATE_W   = 40;
  localparam int PROD_W    = COEF_W + SAMPLE_W;
  localparam int ACC_W     = STATE_W + 1;

  // configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IW = 3;

  // register indexes
  typedef enum logic [REG_IW-1:0] {
    REG_FIRST_B0  = 3'd0,
    REG_FIRST_A1  = 3'd1,
    REG_FIRST_A2  = 3'd2,
    REG_SECOND_B0 = 3'd3,
    REG_SECOND_A1 = 3'd4,
    REG_SECOND_A2 = 3'd5
  } cbb_reg_t;

  // coefficient reset values
  localparam logic signed [COEF_W-1:0] RST_FIRST_B0  = 24'sd216038;
  localparam logic signed [COEF_W-1:0] RST_FIRST_A1  = -24'sd6436972;
  localparam logic signed [COEF_W-1:0] RST_FIRST_A2  = 24'sd3762230;
  localparam logic signed [COEF_W-1:0] RST_SECOND_B0 = 24'sd92269;
  localparam logic signed [COEF_W-1:0] RST_SECOND_A1 = -24'sd6637232;
  localparam logic signed [COEF_W-1:0] RST_SECOND_A2 = 24'sd4009765;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MB0,
    ST_ACC,
    ST_MA1,
    ST_DA,
    ST_DB,
    ST_OUT
  } cbb_state_t;

  // control word for the shared multiply-add unit
  typedef struct packed {
    logic mul_en;
    logic sub;
  } cbb_mac_ctl_t;

  // saturate a one-bit-grown sum to the state width
  function automatic logic signed [STATE_W-1:0] sat_state(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [STATE_W-1:0] r;
    if (v[ACC_W-1] != v[ACC_W-2]) begin
      r = v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    end else begin
      r = v[STATE_W-1:0];
    end
    return r;
  endfunction

  // round half up by the coefficient scale, then saturate to a sample
  function automatic logic signed [SAMPLE_W-1:0] round_sat_sample(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0]       t;
    logic signed [ACC_W-1:0]       s;
    logic [ACC_W-SAMPLE_W:0]       hi;
    logic signed [SAMPLE_W-1:0]    r;
    t  = v + (ACC_W'(1) <<< (COEF_FRAC - 1));
    s  = t >>> COEF_FRAC;
    hi = s[ACC_W-1:SAMPLE_W-1];
    if ((&hi) || !(|hi)) begin
      r = s[SAMPLE_W-1:0];
    end else if (s[ACC_W-1]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- hdl/cascaded_biquad_bandpass.sv -----
// ----------------------------------------------------------------------------
// cascaded_biquad_bandpass
// Two cascaded bandpass biquad sections in transposed direct form II.
// ----------------------------------------------------------------------------
// Usage: one signed Q4.12 sample is taken on the in_ stream channel, run
// through two bandpass sections (b1 = 0, b2 = -b0) and one filtered,
// saturated sample leaves on the out_ stream channel.
// Coefficients b0, a1, a2 of each section sit in six APB registers at byte
// addresses 0x00..0x14 (Q2.22, low 24 bits used); write them only while idle.
// Timing: a single multiplier and a single wide adder are shared by all
// steps, five sequencer steps per section, followed by an output step that
// loads the output register. The result becomes valid in the same cycle
// that in_tready returns, so a new sample is accepted only after the last
// one has been loaded into the output register.
// Reset (rst_n low, synchronous) clears all four state words, loads the
// default coefficients and empties the output register.
// Stall: while a finished sample waits on out_tready the block still accepts
// and computes the next one; it then holds in its final step until the
// output register frees up.
// ----------------------------------------------------------------------------
module cascaded_biquad_bandpass (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream: [15:0] sample_in
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [cbb_pkg::SAMPLE_W-1:0]  in_tdata,
  // output stream: [15:0] sample_out
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [cbb_pkg::SAMPLE_W-1:0]  out_tdata,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [cbb_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [cbb_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [cbb_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);
  import cbb_pkg::*;

  cbb_state_t state_r, state_nxt;

  logic signed [COEF_W-1:0]   b0_r [2];
  logic signed [COEF_W-1:0]   a1_r [2];
  logic signed [COEF_W-1:0]   a2_r [2];
  logic signed [STATE_W-1:0]  da_r [2];
  logic signed [STATE_W-1:0]  db_r [2];

  logic                       sec_r;
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0] y_r;
  logic signed [ACC_W-1:0]    nb_r;
  logic [SAMPLE_W-1:0]        out_tdata_r;
  logic                       out_tvalid_r;

  cbb_mac_ctl_t               mac_ctl;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [SAMPLE_W-1:0] mul_b;
  logic signed [ACC_W-1:0]    add_a;
  logic signed [ACC_W-1:0]    sum;

  logic                       cfg_wr;
  logic [REG_IW-1:0]          cfg_idx;
  logic                       out_free;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[REG_IW+1:2];
  assign out_free   = !out_tvalid_r || out_tready;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r[0] <= RST_FIRST_B0;
      a1_r[0] <= RST_FIRST_A1;
      a2_r[0] <= RST_FIRST_A2;
      b0_r[1] <= RST_SECOND_B0;
      a1_r[1] <= RST_SECOND_A1;
      a2_r[1] <= RST_SECOND_A2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FIRST_B0:  b0_r[0] <= cfg_pwdata[COEF_W-1:0];
        REG_FIRST_A1:  a1_r[0] <= cfg_pwdata[COEF_W-1:0];
        REG_FIRST_A2:  a2_r[0] <= cfg_pwdata[COEF_W-1:0];
        REG_SECOND_B0: b0_r[1] <= cfg_pwdata[COEF_W-1:0];
        REG_SECOND_A1: a1_r[1] <= cfg_pwdata[COEF_W-1:0];
        REG_SECOND_A2: a2_r[1] <= cfg_pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // register read-back, sign extended
  always_comb begin
    case (cfg_idx)
      REG_FIRST_B0:  cfg_prdata = CFG_DW'(b0_r[0]);
      REG_FIRST_A1:  cfg_prdata = CFG_DW'(a1_r[0]);
      REG_FIRST_A2:  cfg_prdata = CFG_DW'(a2_r[0]);
      REG_SECOND_B0: cfg_prdata = CFG_DW'(b0_r[1]);
      REG_SECOND_A1: cfg_prdata = CFG_DW'(a1_r[1]);
      REG_SECOND_A2: cfg_prdata = CFG_DW'(a2_r[1]);
      default:       cfg_prdata = '0;
    endcase
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and operand selection
  always_comb begin
    state_nxt      = state_r;
    mac_ctl.mul_en = 1'b0;
    mac_ctl.sub    = 1'b1;
    mul_a          = b0_r[sec_r];
    mul_b          = x_r;
    add_a          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_MB0;
      end
      ST_MB0: begin
        mac_ctl.mul_en = 1'b1;
        state_nxt      = ST_ACC;
      end
      ST_ACC: begin
        // b0*x plus first delay word
        mac_ctl.sub = 1'b0;
        add_a       = ACC_W'(da_r[sec_r]);
        state_nxt   = ST_MA1;
      end
      ST_MA1: begin
        // negate b0*x while a1*y is formed
        mac_ctl.mul_en = 1'b1;
        mul_a          = a1_r[sec_r];
        mul_b          = y_r;
        state_nxt      = ST_DA;
      end
      ST_DA: begin
        // db - a1*y while a2*y is formed
        mac_ctl.mul_en = 1'b1;
        mul_a          = a2_r[sec_r];
        mul_b          = y_r;
        add_a          = ACC_W'(db_r[sec_r]);
        state_nxt      = ST_DB;
      end
      ST_DB: begin
        add_a     = nb_r;
        state_nxt = sec_r ? ST_OUT : ST_MB0;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // shared multiply-add unit
  cbb_mac u_mac (
    .clk   (clk),
    .ctl   (mac_ctl),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .add_a (add_a),
    .sum   (sum)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r   <= 1'b0;
      da_r[0] <= '0;
      da_r[1] <= '0;
      db_r[0] <= '0;
      db_r[1] <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            x_r   <= in_tdata;
            sec_r <= 1'b0;
          end
        end
        ST_ACC:  y_r <= round_sat_sample(sum);
        ST_MA1:  nb_r <= sum;
        ST_DA:   da_r[sec_r] <= sat_state(sum);
        ST_DB: begin
          db_r[sec_r] <= sat_state(sum);
          x_r         <= y_r;
          sec_r       <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_tdata_r <= y_r;
    end
  end

`ifndef SYNTHESIS
  // an accepted sample always starts at the first section
  a_start_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !sec_r && state_r == ST_MB0)
    else $error("sample did not start in the first section");

  // the output slot is only filled from the output step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && $past(rst_n) ##1 out_tvalid |-> $past(state_r == ST_OUT))
    else $error("output loaded outside the output step");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("pending result was lost");

  // the second pass always finishes before the output step
  a_out_after_second: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> sec_r)
    else $error("output step reached before the second section");
`endif

endmodule

// ----- hdl/cbb_mac.sv -----
// ----------------------------------------------------------------------------
// cbb_mac
// Shared multiply-add unit: a registered coefficient-by-sample product and
// one wide adder that adds or subtracts that product.
// ----------------------------------------------------------------------------
module cbb_mac (
  input  logic                                 clk,
  input  cbb_pkg::cbb_mac_ctl_t                ctl,
  input  logic signed [cbb_pkg::COEF_W-1:0]    mul_a,
  input  logic signed [cbb_pkg::SAMPLE_W-1:0]  mul_b,
  input  logic signed [cbb_pkg::ACC_W-1:0]     add_a,
  output logic signed [cbb_pkg::ACC_W-1:0]     sum
);
  import cbb_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_ext;

  // product register, loaded on request from the sequencer
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  // add or subtract the held product
  assign prod_ext = ACC_W'(prod_r);
  assign sum = add_a + (prod_ext ^ {ACC_W{ctl.sub}}) + ACC_W'(ctl.sub);

endmodule

// ----- sim/cbb_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbb_tb_pkg
// Scoreboard for the bandpass biquad cascade: a bit-exact fixed-point
// predictor of both sections and the queue of filtered samples it expects.
// ----------------------------------------------------------------------------
package cbb_tb_pkg;
  import cbb_pkg::*;

  class cbb_scoreboard;
    // per-section coefficients and delay words, index 0 is the first section
    longint gain[2];
    longint fb1[2];
    longint fb2[2];
    longint delay_a[2];
    longint delay_b[2];
    logic [SAMPLE_W-1:0] filtered_q[$];
    int mismatches;
    int checked;

    function new();
      gain[0]    = RST_FIRST_B0;
      fb1[0]     = RST_FIRST_A1;
      fb2[0]     = RST_FIRST_A2;
      gain[1]    = RST_SECOND_B0;
      fb1[1]     = RST_SECOND_A1;
      fb2[1]     = RST_SECOND_A2;
      delay_a    = '{0, 0};
      delay_b    = '{0, 0};
      mismatches = 0;
      checked    = 0;
    endfunction

    // register write, only the low coefficient bits count
    function void load_coef(logic [REG_IW-1:0] idx, logic [CFG_DW-1:0] value);
      longint v;
      v = longint'($signed(value[COEF_W-1:0]));
      case (idx)
        REG_FIRST_B0:  gain[0] = v;
        REG_FIRST_A1:  fb1[0]  = v;
        REG_FIRST_A2:  fb2[0]  = v;
        REG_SECOND_B0: gain[1] = v;
        REG_SECOND_A1: fb1[1]  = v;
        REG_SECOND_A2: fb2[1]  = v;
        default: ;
      endcase
    endfunction

    function longint clamp_to(longint v, int w);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    // one transposed direct form II section with b1 = 0 and b2 = -b0
    function longint run_section(int s, longint x);
      longint acc;
      longint y;
      longint na;
      longint nb;
      acc = gain[s] * x + delay_a[s];
      // floor shift after adding half gives round half up
      y  = clamp_to((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, SAMPLE_W);
      na = -(fb1[s] * y) + delay_b[s];
      nb = -(gain[s] * x) - fb2[s] * y;
      delay_a[s] = clamp_to(na, STATE_W);
      delay_b[s] = clamp_to(nb, STATE_W);
      return y;
    endfunction

    // accepted input request: filter it and queue the expected sample
    function void note_sample(logic [SAMPLE_W-1:0] raw);
      longint y1;
      longint y2;
      y1 = run_section(0, longint'($signed(raw)));
      y2 = run_section(1, y1);
      filtered_q.push_back(y2[SAMPLE_W-1:0]);
    endfunction

    // accepted output request: compare against the oldest expected sample
    function void check_output(logic [SAMPLE_W-1:0] got);
      logic [SAMPLE_W-1:0] want;
      checked++;
      if (filtered_q.size() == 0) begin
        mismatches++;
        $error("sample_out: expected none, actual %0d", $signed(got));
        return;
      end
      want = filtered_q.pop_front();
      if (want !== got) begin
        mismatches++;
        $error("sample_out: expected %0d, actual %0d", $signed(want), $signed(got));
      end
    endfunction

    function int pending();
      return filtered_q.size();
    endfunction
  endclass

endpackage

// ----- sim/tb_cascaded_biquad_bandpass.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cascaded_biquad_bandpass
// Streams signed samples through the biquad cascade under several coefficient
// sets (reset, half gain, both extremes, random) with bursty input and a
// stalling receiver, and compares every output sample with the scoreboard.
// ----------------------------------------------------------------------------
module tb_cascaded_biquad_bandpass;
  import cbb_pkg::*;
  import cbb_tb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int LONG_HOLD      = 300;
  localparam int HOLD_AFTER     = 200;
  localparam int PAD_W          = CFG_DW - COEF_W;

  localparam logic [REG_IW-1:0] REG_UNMAPPED_LO = 3'd6;
  localparam logic [REG_IW-1:0] REG_UNMAPPED_HI = 3'd7;

  localparam logic [COEF_W-1:0] COEF_MAX  = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN  = {1'b1, {(COEF_W-1){1'b0}}};
  localparam logic [COEF_W-1:0] COEF_HALF = COEF_W'(1) << (COEF_FRAC - 1);
  localparam logic [COEF_W-1:0] COEF_ZERO = '0;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_NEG = '1;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata;     // [15:0] sample_in
  logic                out_tvalid;
  logic                out_tready;
  logic [SAMPLE_W-1:0] out_tdata;    // [15:0] sample_out
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [CFG_AW-1:0]   cfg_paddr;
  logic [CFG_DW-1:0]   cfg_pwdata;
  logic [CFG_DW-1:0]   cfg_prdata;
  logic                cfg_pready;

  cbb_scoreboard       sb;
  int                  quiet_cycles = 0;
  logic [SAMPLE_W-1:0] last_sample = '0;

  cascaded_biquad_bandpass u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // apb write, junk in the unused upper bits
  task automatic write_reg(input logic [REG_IW-1:0] idx, input logic [COEF_W-1:0] coef);
    logic [CFG_DW-1:0] word;
    word = {PAD_W'($urandom()), coef};
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.load_coef(idx, word);
  endtask

  // full coefficient set plus a write to an unmapped slot
  task automatic set_coefs(input logic [COEF_W-1:0] b0a, input logic [COEF_W-1:0] a1a,
                           input logic [COEF_W-1:0] a2a, input logic [COEF_W-1:0] b0b,
                           input logic [COEF_W-1:0] a1b, input logic [COEF_W-1:0] a2b);
    write_reg(REG_FIRST_B0, b0a);
    write_reg(REG_FIRST_A1, a1a);
    write_reg(REG_FIRST_A2, a2a);
    write_reg(REG_SECOND_B0, b0b);
    write_reg(REG_SECOND_A1, a1b);
    write_reg(REG_SECOND_A2, a2b);
    write_reg($urandom_range(0, 1) ? REG_UNMAPPED_HI : REG_UNMAPPED_LO, COEF_W'($urandom()));
  endtask

  // leaves valid high so back-to-back requests stay continuous
  task automatic send_sample(input logic [SAMPLE_W-1:0] v);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    logic [8:0]          narrow;
    narrow = 9'($urandom());
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      1, 2:    v = {{(SAMPLE_W-9){narrow[8]}}, narrow};
      3:       v = last_sample;
      default: v = SAMPLE_W'($urandom());
    endcase
    last_sample = v;
    return v;
  endfunction

  // random samples in bursts with random gaps
  task automatic play_random(input int n);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_sample(pick_sample());
      left -= burst;
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // wait until the block is idle before touching coefficients
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // handshake monitor and quiet-cycle counter
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_sample(in_tdata);
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // watchdog
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall pattern, with one long hold-off while the sender offers
  initial begin
    int  span;
    int  mode;
    bit  held;
    held = 1'b0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER && in_tvalid) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        span = $urandom_range(1, 40);
        mode = $urandom_range(0, 3);
        repeat (span) begin
          case (mode)
            0:       out_tready <= 1'b1;
            1:       out_tready <= 1'($urandom());
            2:       out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // main sequence
  initial begin
    sb = new();
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients: zero, extremes, alternating, unit steps
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_ONE);
    send_sample(SAMPLE_NEG);
    send_sample(16'h5555);
    play_random(100);
    finish_phase();

    // half gain, no feedback: odd differences land exactly on halves
    set_coefs(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_HALF, COEF_ZERO, COEF_ZERO);
    send_sample(SAMPLE_ONE);
    send_sample(SAMPLE_NEG);
    send_sample(16'd3);
    send_sample(16'hFFFD);
    send_sample(SAMPLE_ONE);
    send_sample('0);
    play_random(120);
    finish_phase();

    // largest coefficients: output and state saturation
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    play_random(120);
    finish_phase();

    // most negative coefficients
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    play_random(120);
    finish_phase();

    // random coefficient sets
    repeat (3) begin
      set_coefs(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
                COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()));
      play_random(150);
      finish_phase();
    end

    // back to the bandpass defaults
    set_coefs(RST_FIRST_B0, RST_FIRST_A1, RST_FIRST_A2,
              RST_SECOND_B0, RST_SECOND_A1, RST_SECOND_A2);
    play_random(340);
    finish_phase();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
